### src/fpd_pkg.sv
// ---------------------------------------------------------------------------
// fpd_pkg
// shared types and constants of the datagram deframer
// ---------------------------------------------------------------------------
`default_nettype none

package fpd_pkg;

    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned SIZE_BITS    = 24;
    localparam int unsigned SUM_BITS     = 16;
    localparam int unsigned INDEX_BITS   = 4;
    localparam int unsigned PPF_BITS     = 5;

    localparam logic [PPF_BITS-1:0]   PPF_RESET  = 5'd4;
    localparam logic [PPF_BITS-1:0]   PPF_MAX    = 5'd16;
    localparam logic [INDEX_BITS-1:0] INDEX_MASK = 4'hf;

    // header byte positions
    localparam logic [2:0] HDR_INDEX  = 3'd0;
    localparam logic [2:0] HDR_SUM_LO = 3'd1;
    localparam logic [2:0] HDR_SUM_HI = 3'd2;
    localparam logic [2:0] HDR_SIZE_0 = 3'd3;
    localparam logic [2:0] HDR_SIZE_1 = 3'd4;
    localparam logic [2:0] HDR_SIZE_2 = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } fpd_item_t;

    typedef struct packed {
        logic                  length_ok;
        logic                  sum_ok;
        logic                  in_sequence;
        logic [INDEX_BITS-1:0] packet_index;
        logic                  frame_end;
        logic                  frame_good;
        logic [SIZE_BITS-1:0]  payload_length;
    } fpd_status_t;

    // last index of a frame, register clamped to 1..16
    function automatic logic [INDEX_BITS-1:0] last_index(input logic [PPF_BITS-1:0] ppf);
        logic [INDEX_BITS-1:0] result;
        if (ppf == '0)
        begin
            result = '0;
        end
        else if (ppf >= PPF_MAX)
        begin
            result = INDEX_MASK;
        end
        else
        begin
            result = INDEX_BITS'(ppf - 5'd1);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

### src/fpd_if.sv
// ---------------------------------------------------------------------------
// fpd channel interfaces
// byte input channel and status output channel, valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface fpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fpd_status_if;
    logic        valid;
    logic        ready;
    logic        length_ok;
    logic        sum_ok;
    logic        in_sequence;
    logic [3:0]  packet_index;
    logic        frame_end;
    logic        frame_good;
    logic [23:0] payload_length;

    modport source (
        output valid, output length_ok, output sum_ok, output in_sequence,
        output packet_index, output frame_end, output frame_good,
        output payload_length, input ready
    );
    modport sink (
        input valid, input length_ok, input sum_ok, input in_sequence,
        input packet_index, input frame_end, input frame_good,
        input payload_length, output ready
    );
endinterface

`default_nettype wire

### src/fpd_in_stage.sv
// ---------------------------------------------------------------------------
// fpd_in_stage
// input register for one byte transfer, refilled in the cycle it drains
// ---------------------------------------------------------------------------
`default_nettype none

module fpd_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire fpd_pkg::fpd_item_t in_item,
    output logic                   in_ready,
    output logic                   item_valid,
    output fpd_pkg::fpd_item_t     item,
    input  wire logic              item_take
);

    logic               valid_reg;
    logic               valid_next;
    fpd_pkg::fpd_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = in_valid || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### src/fpd_check.sv
// ---------------------------------------------------------------------------
// fpd_check
// byte count, header store, payload sum, sequence state and result register
// ---------------------------------------------------------------------------
`default_nettype none

module fpd_check #(
    parameter int unsigned COUNT_BITS = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [fpd_pkg::PPF_BITS-1:0]     cfg_wr_data,
    input  wire logic                             item_valid,
    input  wire fpd_pkg::fpd_item_t               item,
    output logic                                  item_take,
    output logic                                  status_valid,
    output fpd_pkg::fpd_status_t                  status,
    input  wire logic                             status_ready
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] HDR_COUNT = COUNT_BITS'(fpd_pkg::HEADER_BYTES);
    localparam logic [fpd_pkg::INDEX_BITS-1:0] PREV_RESET =
        fpd_pkg::INDEX_BITS'(fpd_pkg::PPF_RESET - 5'd1);

    logic [fpd_pkg::PPF_BITS-1:0]   ppf_reg;
    logic [COUNT_BITS-1:0]          count_reg;
    logic [COUNT_BITS-1:0]          count_next;
    logic [fpd_pkg::SUM_BITS-1:0]   sum_reg;
    logic [fpd_pkg::SUM_BITS-1:0]   sum_next;
    logic [fpd_pkg::INDEX_BITS-1:0] prev_reg;
    logic [fpd_pkg::INDEX_BITS-1:0] prev_next;
    logic                           in_order_reg;
    logic                           in_order_next;
    logic [7:0]                     hdr_reg [fpd_pkg::HEADER_BYTES];
    logic [7:0]                     hdr_view [fpd_pkg::HEADER_BYTES];
    logic                           out_valid_reg;
    fpd_pkg::fpd_status_t           out_reg;
    fpd_pkg::fpd_status_t           status_next;

    logic                           out_free;
    logic                           in_header;
    logic                           is_last;
    logic [fpd_pkg::SIZE_BITS-1:0]  size_field;
    logic [fpd_pkg::SUM_BITS-1:0]   sum_field;
    logic [fpd_pkg::INDEX_BITS-1:0] idx;
    logic [fpd_pkg::INDEX_BITS-1:0] lidx;
    logic [fpd_pkg::INDEX_BITS-1:0] expect_idx;
    logic                           long_enough;
    logic                           match;
    logic                           seq_ok;
    logic                           at_end;

    assign out_free  = !out_valid_reg || status_ready;
    assign item_take = item_valid && (!item.last_byte || out_free);
    assign is_last   = item_take && item.last_byte;
    assign in_header = count_reg < HDR_COUNT;

    // header as seen after this byte is stored
    always_comb
    begin
        for (int i = 0; i < fpd_pkg::HEADER_BYTES; i++)
        begin
            if (in_header && count_reg[2:0] == 3'(i))
            begin
                hdr_view[i] = item.data_byte;
            end
            else
            begin
                hdr_view[i] = hdr_reg[i];
            end
        end
    end

    always_comb
    begin
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        sum_next   = in_header ? sum_reg
                   : sum_reg + fpd_pkg::SUM_BITS'(item.data_byte);
    end

    assign size_field  = {hdr_view[fpd_pkg::HDR_SIZE_2], hdr_view[fpd_pkg::HDR_SIZE_1],
                          hdr_view[fpd_pkg::HDR_SIZE_0]};
    assign sum_field   = {hdr_view[fpd_pkg::HDR_SUM_HI], hdr_view[fpd_pkg::HDR_SUM_LO]};
    assign idx         = hdr_view[fpd_pkg::HDR_INDEX][fpd_pkg::INDEX_BITS-1:0];
    assign lidx        = fpd_pkg::last_index(ppf_reg);
    assign expect_idx  = (idx == '0) ? lidx : idx - 1'b1;
    assign long_enough = count_next >= HDR_COUNT;
    assign match       = long_enough && (count_next != COUNT_MAX)
                      && (fpd_pkg::SIZE_BITS'(count_next) == size_field);
    assign seq_ok      = expect_idx == prev_reg;
    assign at_end      = idx == lidx;

    always_comb
    begin
        status_next.length_ok      = match;
        status_next.sum_ok         = match && (sum_next == sum_field);
        status_next.in_sequence    = match && seq_ok;
        status_next.packet_index   = idx;
        status_next.frame_end      = match && at_end;
        status_next.frame_good     = match && at_end && in_order_reg && seq_ok;
        status_next.payload_length = long_enough
                                   ? fpd_pkg::SIZE_BITS'(count_next - HDR_COUNT) : '0;
        prev_next     = prev_reg;
        in_order_next = in_order_reg;
        if (match)
        begin
            prev_next     = idx;
            in_order_next = at_end ? 1'b1 : (in_order_reg && seq_ok);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppf_reg       <= fpd_pkg::PPF_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            prev_reg      <= PREV_RESET;
            in_order_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ppf_reg <= cfg_wr_data;
            end
            if (item_take)
            begin
                count_reg <= item.last_byte ? '0 : count_next;
                sum_reg   <= item.last_byte ? '0 : sum_next;
            end
            if (is_last)
            begin
                prev_reg     <= prev_next;
                in_order_reg <= in_order_next;
            end
            if (is_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && in_header)
        begin
            hdr_reg[count_reg[2:0]] <= item.data_byte;
        end
        if (is_last)
        begin
            out_reg <= status_next;
        end
    end

    assign status_valid = out_valid_reg;
    assign status       = out_reg;

    // a last byte transfer always leaves a result waiting
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        is_last |=> out_valid_reg)
        else $error("no result after last byte");

    // count and sum restart after each datagram
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        is_last |=> (count_reg == '0 && sum_reg == '0))
        else $error("count or sum not cleared after last byte");

    // a length mismatch reports no check as passed
    a_mismatch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.length_ok) |->
        (!out_reg.sum_ok && !out_reg.in_sequence && !out_reg.frame_end
         && !out_reg.frame_good))
        else $error("checks passed on length mismatch");

    // sequence state moves only on a matching datagram
    a_prev_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(is_last && match) |=> $stable(prev_reg))
        else $error("previous index changed without a length match");

endmodule

`default_nettype wire

### src/frame_packet_deframer.sv
// ---------------------------------------------------------------------------
// frame_packet_deframer
// checks header size, payload sum and packet sequence of byte-wise datagrams
// ---------------------------------------------------------------------------
//  channel   dir   transfer moves
//  bytes     in    data_byte, last_byte
//  status    out   length_ok, sum_ok, in_sequence, packet_index, frame_end,
//                  frame_good, payload_length (one per last byte)
//  cfg       in    packets_per_frame, written when cfg_wr_en is high
//
//  one byte per cycle unless a held status stalls a last byte; a status is valid
//  once its last byte has passed the input register, then the result register
//  reset clears count, sum, sequence state and the register to 4
//  a held status stalls only last bytes; other bytes keep flowing
// ---------------------------------------------------------------------------
`default_nettype none

module frame_packet_deframer #(
    parameter int unsigned COUNT_BITS = 24
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [4:0] cfg_wr_data,
    fpd_byte_if.sink        bytes,
    fpd_status_if.source    status
);

    fpd_pkg::fpd_item_t   in_item;
    fpd_pkg::fpd_item_t   item;
    fpd_pkg::fpd_status_t result;
    logic                 item_valid;
    logic                 item_take;
    logic                 result_valid;

    assign in_item.data_byte = bytes.data_byte;
    assign in_item.last_byte = bytes.last_byte;

    fpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (bytes.valid),
        .in_item    (in_item),
        .in_ready   (bytes.ready),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    fpd_check #(
        .COUNT_BITS (COUNT_BITS)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take),
        .status_valid (result_valid),
        .status       (result),
        .status_ready (status.ready)
    );

    assign status.valid          = result_valid;
    assign status.length_ok      = result.length_ok;
    assign status.sum_ok         = result.sum_ok;
    assign status.in_sequence    = result.in_sequence;
    assign status.packet_index   = result.packet_index;
    assign status.frame_end      = result.frame_end;
    assign status.frame_good     = result.frame_good;
    assign status.payload_length = result.payload_length;

endmodule

`default_nettype wire
